[sv/assert_macros.svh]
// Assertion macros used by the sector run allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define SBRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SBRA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBRA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/sbra_pkg.sv]
// Types, constants and helpers of the sector run allocator.
package sbra_pkg;

    localparam int MAX_SECTORS  = 1024;
    localparam int ROWS         = MAX_SECTORS / 8;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int SEC_W        = 10;
    localparam int CNT_W        = $clog2(MAX_SECTORS) + 1;
    localparam int LEN_W        = 16;
    localparam int NEED_W       = 5;
    localparam int SECTOR_BYTES = 4096;
    localparam int SECT_SH      = $clog2(SECTOR_BYTES);
    localparam int SPAN_W       = CNT_W;
    localparam int URW          = SPAN_W - 3;

    typedef enum logic [1:0] {
        REQ_FORMAT  = 2'd0,
        REQ_ALLOC   = 2'd1,
        REQ_MARK    = 2'd2,
        REQ_RELEASE = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic [SEC_W-1:0]   start_sector;
        logic [LEN_W-1:0]   byte_length;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [SEC_W-1:0]   run_start;
        logic [CNT_W-1:0]   free_sectors;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT,
        S_SCAN,
        S_UPD_RD,
        S_UPD_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic fmt;
        logic scan;
        logic upd_rd;
        logic upd_wr;
    } t_cmd;

    typedef struct packed {
        logic fmt_last;
        logic found;
        logic exhausted;
        logic need_zero;
        logic skip;
    } t_sts;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

endpackage

[sv/sbra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sbra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sbra_ctrl.sv]
// Request sequencer of the sector run allocator.
module sbra_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sbra_pkg::t_req_type i_req_type,
    input  sbra_pkg::t_sts      i_sts,
    output sbra_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_done
);
    import sbra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req_type)
                        REQ_FORMAT: n_state = S_FMT;
                        REQ_ALLOC:  n_state = S_SCAN;
                        default:    n_state = S_UPD_RD;
                    endcase
                end
            end
            S_FMT: begin
                if (i_sts.fmt_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.found) begin
                    n_state = i_sts.need_zero ? S_DONE : S_UPD_RD;
                end else if (i_sts.exhausted) begin
                    n_state = S_DONE;
                end
            end
            S_UPD_RD: begin
                n_state = i_sts.skip ? S_DONE : S_UPD_WR;
            end
            S_UPD_WR: begin
                n_state = S_UPD_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.fmt    = (r_state == S_FMT);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.upd_rd = (r_state == S_UPD_RD) && !i_sts.skip;
        o_cmd.upd_wr = (r_state == S_UPD_WR);
        o_busy       = (r_state != S_IDLE);
        o_done       = (r_state == S_DONE);
    end

endmodule

[sv/sbra_dp.sv]
// Free map storage, run search and run update datapath of the allocator.
module sbra_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [sbra_pkg::CNT_W-1:0] i_cfg_data,
    input  sbra_pkg::t_req            i_req,
    input  sbra_pkg::t_cmd            i_cmd,
    output sbra_pkg::t_sts            o_sts,
    output sbra_pkg::t_result         o_result
);
    import sbra_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [ROW_W:0]    r_rows;
    t_req_type         r_req_type;
    logic [NEED_W-1:0] r_need;
    logic [ROW_W:0]    r_addr;
    logic              r_pv;
    logic [ROW_W-1:0]  r_prow;
    logic [NEED_W-1:0] r_run;
    logic [SEC_W-1:0]  r_begin;
    logic [SPAN_W-1:0] r_ubeg;
    logic [SPAN_W-1:0] r_uend;
    logic [URW-1:0]    r_urow;
    logic [CNT_W-1:0]  r_total;
    logic              r_ok;
    logic [SEC_W-1:0]  r_run_start;
    logic [ROWS-1:0]   r_valid;
    logic              r_rv;

    logic [CNT_W-4:0]  raw_rows;
    logic [ROW_W:0]    act_rows;
    logic [LEN_W:0]    len_sum;
    logic [NEED_W-1:0] need_in;
    logic [NEED_W-1:0] want;
    logic [7:0]        rd_byte;
    logic [NEED_W-1:0] run_o;
    logic [SEC_W-1:0]  beg_o;
    logic              hit;
    logic              addr_in;
    logic [SPAN_W-1:0] base;
    logic [7:0]        mask;
    logic              uval;
    logic [7:0]        new_byte;
    logic [3:0]        flips;

    logic              ram_we;
    logic [ROW_W-1:0]  ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ROW_W-1:0]  ram_raddr;
    logic [7:0]        ram_rdata;

    sbra_ram #(
        .WIDTH(8),
        .DEPTH(ROWS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign raw_rows = r_count[CNT_W-1:3];
    assign act_rows = (raw_rows > (CNT_W-3)'(ROWS)) ? (ROW_W+1)'(ROWS)
                                                    : (ROW_W+1)'(raw_rows);
    assign len_sum  = {1'b0, i_req.byte_length} + (LEN_W+1)'(SECTOR_BYTES - 1);
    assign need_in  = NEED_W'(len_sum >> SECT_SH);
    assign want     = (r_need == '0) ? NEED_W'(1) : r_need;
    assign rd_byte  = r_rv ? ram_rdata : 8'h00;
    assign addr_in  = (r_addr < r_rows);

    always_comb begin
        logic [NEED_W-1:0] run;
        logic [SEC_W-1:0]  beg;
        logic              f;
        run = r_run;
        beg = r_begin;
        f   = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!f) begin
                if (rd_byte[i]) begin
                    if (run == '0) begin
                        beg = {r_prow, 3'(i)};
                    end
                    run = run + NEED_W'(1);
                    if (run >= want) begin
                        f = 1'b1;
                    end
                end else begin
                    run = '0;
                end
            end
        end
        run_o = run;
        beg_o = beg;
        hit   = f;
    end

    assign base = {r_urow, 3'b000};
    assign uval = (r_req_type == REQ_RELEASE);

    always_comb begin
        logic [SPAN_W-1:0] pos;
        for (int i = 0; i < 8; i++) begin
            pos     = base + SPAN_W'(i);
            mask[i] = (pos >= r_ubeg) && (pos < r_uend);
        end
        new_byte = uval ? (rd_byte | mask) : (rd_byte & ~mask);
        flips    = popcount8(mask & (uval ? ~rd_byte : rd_byte));
    end

    always_comb begin
        o_sts           = '0;
        o_sts.fmt_last  = (r_addr[ROW_W-1:0] == ROW_W'(ROWS - 1));
        o_sts.found     = i_cmd.scan && r_pv && hit;
        o_sts.exhausted = i_cmd.scan && !r_pv && !addr_in;
        o_sts.need_zero = (r_need == '0);
        o_sts.skip      = (base >= r_uend) || ({1'b0, r_urow} >= (URW+1)'(r_rows));
    end

    assign ram_re    = (i_cmd.scan && addr_in) || i_cmd.upd_rd;
    assign ram_raddr = i_cmd.upd_rd ? r_urow[ROW_W-1:0] : r_addr[ROW_W-1:0];
    assign ram_we    = i_cmd.fmt || i_cmd.upd_wr;
    assign ram_waddr = i_cmd.fmt ? r_addr[ROW_W-1:0] : r_urow[ROW_W-1:0];
    assign ram_wdata = i_cmd.fmt ? (({1'b0, r_addr[ROW_W-1:0]} < r_rows) ? 8'hff : 8'h00)
                                 : new_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_valid <= '0;
            r_pv    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (i_cmd.fmt && o_sts.fmt_last) begin
                r_total <= CNT_W'({r_rows, 3'b000});
            end else if (i_cmd.upd_wr) begin
                r_total <= uval ? (r_total + CNT_W'(flips)) : (r_total - CNT_W'(flips));
            end
            if (i_cmd.load) begin
                r_pv <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pv <= addr_in && !o_sts.found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rv <= r_valid[ram_raddr];
        end
        if (i_cmd.load) begin
            r_rows      <= act_rows;
            r_req_type  <= i_req.req_type;
            r_need      <= need_in;
            r_addr      <= '0;
            r_run       <= '0;
            r_begin     <= '0;
            r_ok        <= 1'b1;
            r_run_start <= '0;
            r_ubeg      <= SPAN_W'(i_req.start_sector);
            r_uend      <= SPAN_W'(i_req.start_sector) + SPAN_W'(need_in);
            r_urow      <= URW'(i_req.start_sector >> 3);
        end else begin
            if (i_cmd.fmt) begin
                r_addr <= r_addr + (ROW_W+1)'(1);
            end
            if (i_cmd.scan) begin
                if (addr_in) begin
                    r_addr <= r_addr + (ROW_W+1)'(1);
                end
                r_prow <= r_addr[ROW_W-1:0];
                if (r_pv) begin
                    r_run   <= run_o;
                    r_begin <= beg_o;
                end
                if (o_sts.found) begin
                    r_run_start <= beg_o;
                    r_ubeg      <= SPAN_W'(beg_o);
                    r_uend      <= SPAN_W'(beg_o) + SPAN_W'(r_need);
                    r_urow      <= URW'(beg_o >> 3);
                end
                if (o_sts.exhausted) begin
                    r_ok <= 1'b0;
                end
            end
            if (i_cmd.upd_wr) begin
                r_urow <= r_urow + URW'(1);
            end
        end
    end

    assign o_result.ok           = r_ok;
    assign o_result.run_start    = r_run_start;
    assign o_result.free_sectors = r_total;

endmodule

[sv/sector_bitmap_run_allocator.sv]
// Top level of the sector run allocator: sequencer, datapath and checks.
// Usage: a request word (format, alloc, mark_used or release) is taken on i_req
// at a clock edge where start is high and busy is low. The block then stays
// busy and finally shows one result word on o_result, marked by o_done, which
// is high for exactly one cycle; the receiver cannot stall it.
// The sector count register is written over the i_cfg_valid / o_cfg_ready
// channel, which is ready whenever the block is not busy.
// Work per request, bounded by the one read port of the byte-wide
// free map memory (one byte of eight sectors per cycle):
//   format: writes all 128 free map rows.
//   alloc: searches the active rows, then reads and writes back each
//   map byte that the run touches (at most three).
//   mark_used and release: read and write back each touched byte.
// One request is worked on at a time. Reset marks every sector used, clears
// the free total and the sector count, and returns to idle.
`include "assert_macros.svh"
module sector_bitmap_run_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sbra_pkg::t_req             i_req,
    output logic                       o_done,
    output sbra_pkg::t_result          o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sbra_pkg::CNT_W-1:0] i_cfg_data
);
    import sbra_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    sbra_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req_type(i_req.req_type),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    sbra_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_req     (i_req),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_result  (o_result)
    );

    `SBRA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `SBRA_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `SBRA_ASSERT_IMP(a_total_range, i_clk, i_rst_n, o_done, o_result.free_sectors <= CNT_W'(MAX_SECTORS))
    `SBRA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && !o_result.ok, o_result.run_start == '0)

endmodule
